### rtl/ibhq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibhq_pkg
// Shared widths, mode and status codes for the indexed binary heap queue.
// ----------------------------------------------------------------------------
package ibhq_pkg;
  localparam int Capacity = 64;
  localparam int IdCount  = 64;
  localparam int KeyBits  = 32;
  localparam int SlotW    = $clog2(Capacity);
  localparam int IdW      = 6;
  localparam int CntW     = 7;

  localparam logic [2:0] MODE_PUSH   = 3'd0;
  localparam logic [2:0] MODE_POP    = 3'd1;
  localparam logic [2:0] MODE_PEEK   = 3'd2;
  localparam logic [2:0] MODE_UPDATE = 3'd3;
  localparam logic [2:0] MODE_GET    = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_WRONG_DIR = 3'd4;
  localparam logic [2:0] ST_DUPLICATE = 3'd5;

  localparam logic CFG_HEAP_TYPE  = 1'b0;
  localparam logic CFG_KEY_SIGNED = 1'b1;

  // Heap entry: key and id travel together.
  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic [IdW-1:0]     id;
  } entry_t;

  // True when key a must sit strictly above key b.
  function automatic logic goes_above(input logic [KeyBits-1:0] a,
                                      input logic [KeyBits-1:0] b,
                                      input logic max_heap, input logic sgn);
    logic [KeyBits-1:0] fa;
    logic [KeyBits-1:0] fb;
    fa = a ^ {sgn, {(KeyBits-1){1'b0}}};
    fb = b ^ {sgn, {(KeyBits-1){1'b0}}};
    return max_heap ? (fa > fb) : (fa < fb);
  endfunction
endpackage

### rtl/ibhq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibhq_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ibhq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/indexed_binary_heap_queue.sv
`timescale 1ns / 1ps
// Pushes and updates sift the entry up and pops sift the last entry down, one heap
// level at a time through the single read port of the slot memory.
// One request at a time; the next is taken the cycle after the result beat.
// Reset (synchronous, active high) clears count, presence bits, config and control.
// ----------------------------------------------------------------------------
// indexed_binary_heap_queue
// Binary heap priority queue with an id-to-slot position table.
// ----------------------------------------------------------------------------
module indexed_binary_heap_queue
  import ibhq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [IdW-1:0]     item_id,
  input  logic [31:0]        key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [IdW-1:0]     out_id,
  output logic [31:0]        out_key,
  output logic [CntW-1:0]    count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic               cfg_data
);
  typedef enum logic [4:0] {
    S_IDLE, S_POS_RD, S_POS_WT, S_ENT_WT,
    S_UP_RD, S_UP_WT, S_UP_SWAP,
    S_POP_RD, S_POP_WT, S_POP_WR,
    S_DN_L, S_DN_R, S_DN_WT, S_DN_SWAP,
    S_RESP
  } state_t;

  state_t state;
  logic heap_type, key_signed;
  logic [IdCount-1:0] present;
  logic [CntW-1:0] hcount;
  logic [2:0] req_mode;
  logic [IdW-1:0] req_id;
  logic [KeyBits-1:0] req_key;
  logic [SlotW-1:0] cur;      // slot being sifted
  entry_t cur_e;              // entry that travels with the sift
  entry_t lbest;              // best child seen so far
  logic [SlotW-1:0] lslot;
  logic lvalid;

  // Slot memory: one write, one read port.
  logic             s_we;
  logic [SlotW-1:0] s_wa, s_ra;
  entry_t           s_wd, s_rd;
  // Position memory.
  logic             p_we;
  logic [IdW-1:0]   p_wa, p_ra;
  logic [SlotW-1:0] p_wd, p_rd;

  ibhq_ram #(.Width($bits(entry_t)), .Depth(Capacity)) u_slot (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  ibhq_ram #(.Width(SlotW), .Depth(IdCount)) u_pos (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign count     = hcount;

  logic [SlotW-1:0] parent;
  logic [SlotW:0]   lchild, rchild;
  assign parent = SlotW'((cur - 1'b1) >> 1);
  assign lchild = {cur, 1'b1};
  assign rchild = {cur, 1'b1} + 1'b1;

  logic cur_wins_parent, child_wins, up_move;
  assign cur_wins_parent = goes_above(cur_e.key, s_rd.key, heap_type, key_signed);
  // The root has no parent: stop there whatever the read port shows.
  assign up_move = (cur != '0) && cur_wins_parent;

  // Memory port drive: decoded from state. Hold each read address through
  // its wait state so the data lands where it is used.
  always_comb begin
    s_we = 1'b0; s_wa = cur; s_wd = cur_e; s_ra = cur;
    p_we = 1'b0; p_wa = cur_e.id; p_wd = cur; p_ra = req_id;
    child_wins = 1'b0;
    unique case (state)
      S_POS_RD: s_ra = '0;
      S_POS_WT: s_ra = p_rd;
      S_UP_RD, S_UP_WT: s_ra = parent;
      S_UP_SWAP: begin
        // Move parent down into cur; keep its position current.
        s_we = up_move; s_wa = cur; s_wd = s_rd;
        p_we = up_move; p_wa = s_rd.id; p_wd = cur;
      end
      S_POP_RD, S_POP_WT: s_ra = SlotW'(hcount);
      S_DN_L:   s_ra = lchild[SlotW-1:0];
      S_DN_R:   s_ra = rchild[SlotW-1:0];
      S_DN_WT, S_DN_SWAP: begin
        child_wins = lvalid &&
          goes_above(lbest.key, cur_e.key, heap_type, key_signed);
        s_we = child_wins && state == S_DN_SWAP;
        s_wa = cur; s_wd = lbest;
        p_we = s_we; p_wa = lbest.id; p_wd = cur;
      end
      default: ;
    endcase
    // Final placement of the travelling entry.
    if (state == S_UP_SWAP && !up_move) begin
      s_we = 1'b1; s_wa = cur; s_wd = cur_e;
      p_we = 1'b1; p_wa = cur_e.id; p_wd = cur;
    end
    if (state == S_DN_SWAP && !child_wins) begin
      s_we = 1'b1; s_wa = cur; s_wd = cur_e;
      p_we = 1'b1; p_wa = cur_e.id; p_wd = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; heap_type <= 1'b0; key_signed <= 1'b0;
      present <= '0; hcount <= '0; out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_HEAP_TYPE) heap_type <= cfg_data;
            else key_signed <= cfg_data;
          end
          if (in_valid) begin
            req_mode <= mode; req_id <= item_id; req_key <= key;
            status <= ST_OK; out_id <= '0; out_key <= '0;
            state <= S_POS_RD;
          end
        end
        S_POS_RD: begin
          // Decide on the request; position and top reads land next cycle.
          state <= S_RESP;
          case (req_mode)
            MODE_PUSH: begin
              if (present[req_id]) status <= ST_DUPLICATE;
              else if (hcount == CntW'(Capacity)) status <= ST_FULL;
              else begin
                out_id <= req_id; out_key <= req_key;
                present[req_id] <= 1'b1;
                cur <= SlotW'(hcount); cur_e <= '{key: req_key, id: req_id};
                hcount <= hcount + 1'b1;
                state <= (hcount == '0) ? S_UP_SWAP : S_UP_RD;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (hcount == '0) status <= ST_EMPTY;
              else begin
                cur <= '0; state <= S_ENT_WT;
              end
            end
            MODE_UPDATE, MODE_GET: begin
              if (!present[req_id]) status <= ST_NOT_FOUND;
              else state <= S_POS_WT;
            end
            default: ;
          endcase
        end
        S_POS_WT: begin
          cur <= p_rd; state <= S_ENT_WT;
        end
        S_ENT_WT: begin
          // s_rd holds the entry at cur.
          state <= S_RESP;
          if (req_mode == MODE_POP || req_mode == MODE_PEEK) begin
            out_id <= s_rd.id; out_key <= s_rd.key;
            if (req_mode == MODE_POP) begin
              present[s_rd.id] <= 1'b0;
              hcount <= hcount - 1'b1;
              if (hcount > CntW'(1)) state <= S_POP_RD;
            end
          end else begin
            out_id <= req_id; out_key <= s_rd.key;
            if (req_mode == MODE_UPDATE) begin
              if (goes_above(s_rd.key, req_key, heap_type, key_signed))
                status <= ST_WRONG_DIR;
              else begin
                out_key <= req_key;
                cur_e <= '{key: req_key, id: req_id};
                state <= (cur == '0) ? S_UP_SWAP : S_UP_RD;
              end
            end
          end
        end
        S_UP_RD:  state <= S_UP_WT;
        S_UP_WT:  state <= S_UP_SWAP;
        S_UP_SWAP: begin
          if (up_move) begin
            cur <= parent;
            state <= (parent == '0) ? S_UP_SWAP : S_UP_RD;
          end else state <= S_RESP;
        end
        S_POP_RD: state <= S_POP_WT;
        S_POP_WT: state <= S_POP_WR;
        S_POP_WR: begin
          cur_e <= s_rd; cur <= '0; state <= S_DN_L;
        end
        S_DN_L: begin
          lvalid <= 1'b0;
          state <= (lchild < (SlotW+1)'(hcount)) ? S_DN_R : S_DN_SWAP;
        end
        S_DN_R: begin
          // Left child data present now.
          lbest <= s_rd; lslot <= lchild[SlotW-1:0]; lvalid <= 1'b1;
          state <= (rchild < (SlotW+1)'(hcount)) ? S_DN_WT : S_DN_SWAP;
        end
        S_DN_WT: begin
          // Right child data present; keep the left one on a tie.
          if (goes_above(s_rd.key, lbest.key, heap_type, key_signed)) begin
            lbest <= s_rd; lslot <= rchild[SlotW-1:0];
          end
          state <= S_DN_SWAP;
        end
        S_DN_SWAP: begin
          if (child_wins) begin
            cur <= lslot; state <= S_DN_L;
          end else state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (out_ready) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/ibhq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibhq_checker
// Port-level checks on the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
module ibhq_checker
  import ibhq_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [2:0]      status,
  input logic [CntW-1:0] count
);
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Capacity)) else $error("count above capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped while stalled");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken with result pending");
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> count == '0)
    else $error("empty reported with items held");
endmodule

bind indexed_binary_heap_queue ibhq_checker u_ibhq_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .status, .count);
